### rtl/bcsum_pkg.sv
`default_nettype none

package bcsum_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_XOR     = 2'd1,
    MODE_CRC16   = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] seed;
  } cfg_t;

  // CRC-16/IBM-3740, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    begin
      t = b ^ crc[15:8];
      t = t ^ {4'b0, t[7:4]};
      crc16_byte = {crc[7:0], 8'b0} ^ {t[3:0], 12'b0} ^ {3'b0, t, 5'b0} ^ {8'b0, t};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/bcsum_regs.sv
`default_nettype none

module bcsum_regs import bcsum_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output      logic [DATA_W-1:0]   prdata,
  output      logic                pready,
  output      cfg_t                cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_ADD;
      cfg.seed <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE: cfg.mode <= mode_t'(pwdata[1:0]);
        REG_SEED: cfg.seed <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE: prdata = {30'b0, cfg.mode};
      REG_SEED: prdata = cfg.seed;
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bcsum_core.sv
`default_nettype none

module bcsum_core import bcsum_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] checksum,
  output      logic        invalid
);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_data;
  logic        s1_first;
  logic        s1_last;
  logic        s1_adv;

  logic [31:0] running_value;
  logic [31:0] running_value_next;
  logic [31:0] base;
  logic        bad;

  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data  <= data_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  always_comb begin
    base = s1_first ? cfg.seed : running_value;
    case (cfg.mode)
      MODE_ADD:   running_value_next = base + {24'b0, s1_data};
      MODE_XOR:   running_value_next = base ^ {24'b0, s1_data};
      MODE_CRC16: running_value_next = {16'b0, crc16_byte(base[15:0], s1_data)};
      default:    running_value_next = base;
    endcase
  end

  assign bad = (cfg.mode == MODE_INVALID) || (cfg.seed == ALL_ONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
    end else if (s1_adv) begin
      running_value <= running_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      checksum <= bad ? ALL_ONES : running_value_next;
      invalid  <= bad;
    end
  end

endmodule

`default_nettype wire

### rtl/byte_checksum_add_xor_crc16.sv
`default_nettype none

// Byte-serial checksum engine: additive sum mod 2^32, XOR, or CRC-16/IBM-3740
// (poly 0x1021, init from seed, no reflection, no final XOR), picked by the
// mode register. first_byte reloads the running value from seed_value before
// the byte is folded in; last_byte makes one result transfer follow, carrying
// the running value, or all-ones with invalid set when mode is 3 or the seed
// is all-ones. The running value persists across messages. One byte is taken
// every cycle while results drain; a byte passes the input register, then is
// folded into the running value; a last byte also loads the result register
// that presents it. A held result stalls the input only once a further last
// byte reaches the input register.
// Registers (APB, 32-bit): 0x0 mode, 0x4 seed_value. Write them only while idle.

module byte_checksum_add_xor_crc16 import bcsum_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  input  wire logic              last_byte,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [31:0]       checksum,
  output      logic              invalid
);

  cfg_t cfg;

  bcsum_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcsum_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .checksum   (checksum),
    .invalid    (invalid)
  );

endmodule

`default_nettype wire
